// File: hdl/rfft_pkg.sv
// ----------------------------------------------------------------------------
// rfft_pkg: shared constants and types
// Widths, frame geometry and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package rfft_pkg;

    localparam int POINTS        = 64;
    localparam int LOG2_POINTS   = $clog2(POINTS);
    localparam int QUARTER       = POINTS / 4;
    localparam int SAMPLE_BITS   = 16;
    localparam int OUT_BITS      = SAMPLE_BITS + LOG2_POINTS;
    localparam int ACC_BITS      = OUT_BITS + 2;
    localparam int TW_BITS       = 18;
    localparam int TW_FRAC       = 15;
    localparam int STAGE_BITS    = $clog2(LOG2_POINTS);
    localparam int IN_TDATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        WSEL_INPUT,
        WSEL_SUM,
        WSEL_DIFF
    } wsel_t;

    typedef struct packed {
        logic                     work_we;
        wsel_t                    work_wsel;
        logic [LOG2_POINTS-1:0]   work_waddr;
        logic [LOG2_POINTS-1:0]   work_raddr;
        logic                     latch_a;
        logic                     latch_b;
        logic                     mul_en;
        logic [LOG2_POINTS-2:0]   tw_idx;
        logic                     inv;
        logic                     res_we;
        logic [LOG2_POINTS-1:0]   res_waddr;
        logic [LOG2_POINTS-1:0]   res_raddr;
        logic                     out_load;
        logic                     out_last;
    } cmd_t;

endpackage

// File: hdl/rfft_ram.sv
// ----------------------------------------------------------------------------
// rfft_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rfft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/rfft_datapath.sv
// ----------------------------------------------------------------------------
// rfft_datapath: butterfly datapath
// Work and result memories, twiddle lookup, butterfly arithmetic, output
// scaling and saturation, output payload register.
// ----------------------------------------------------------------------------
module rfft_datapath
    import rfft_pkg::*;
(
    input  logic                         clk,
    input  cmd_t                         cmd,
    input  logic [IN_TDATA_BITS-1:0]     in_data,
    output logic [2*OUT_BITS-1:0]        out_data,
    output logic                         out_last
);

    typedef struct packed {
        logic signed [TW_BITS-1:0] c;
        logic signed [TW_BITS-1:0] s;
    } tw_t;

    localparam int DIFF_BITS = ACC_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + TW_BITS;

    function automatic logic signed [TW_BITS-1:0] sine_rom(input logic [LOG2_POINTS-2:0] j);
        logic signed [TW_BITS-1:0] v;
        case (j)
            5'd0:    v = 18'sd0;
            5'd1:    v = 18'sd3212;
            5'd2:    v = 18'sd6393;
            5'd3:    v = 18'sd9512;
            5'd4:    v = 18'sd12540;
            5'd5:    v = 18'sd15447;
            5'd6:    v = 18'sd18205;
            5'd7:    v = 18'sd20788;
            5'd8:    v = 18'sd23170;
            5'd9:    v = 18'sd25330;
            5'd10:   v = 18'sd27246;
            5'd11:   v = 18'sd28899;
            5'd12:   v = 18'sd30274;
            5'd13:   v = 18'sd31357;
            5'd14:   v = 18'sd32138;
            5'd15:   v = 18'sd32610;
            5'd16:   v = 18'sd32768;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    function automatic tw_t twiddle(input logic [LOG2_POINTS-2:0] a);
        tw_t t;
        localparam logic [LOG2_POINTS-2:0] Q = (LOG2_POINTS-1)'(QUARTER);
        localparam logic [LOG2_POINTS-2:0] H = (LOG2_POINTS-1)'(2 * QUARTER - 1);
        if (a <= Q)
        begin
            t.c = (a == '0) ? sine_rom(Q) : sine_rom(Q - a);
            t.s = sine_rom(a);
        end
        else
        begin
            t.c = -sine_rom(a - Q);
            t.s = sine_rom(H - a + 1'b1);
        end
        return t;
    endfunction

    logic [2*ACC_BITS-1:0] work_wdata;
    logic [2*ACC_BITS-1:0] work_rdata;
    logic [2*OUT_BITS-1:0] res_wdata;
    logic [2*OUT_BITS-1:0] res_rdata;

    logic [2*ACC_BITS-1:0] a_reg;
    logic [2*ACC_BITS-1:0] b_reg;
    logic [2*ACC_BITS-1:0] sum_reg;
    logic signed [PROD_BITS-1:0] p_rc_reg;
    logic signed [PROD_BITS-1:0] p_iw_reg;
    logic signed [PROD_BITS-1:0] p_rw_reg;
    logic signed [PROD_BITS-1:0] p_ic_reg;
    logic [2*OUT_BITS-1:0] out_data_reg;
    logic                  out_last_reg;

    tw_t                          tw;
    logic signed [TW_BITS-1:0]    wi;
    logic signed [ACC_BITS-1:0]   ar, ai, br, bi;
    logic signed [DIFF_BITS-1:0]  dr, di;
    logic signed [PROD_BITS:0]    diff_re, diff_im;
    logic [ACC_BITS-1:0]          sum_re, sum_im;
    logic [2*ACC_BITS-1:0]        diff_word;
    logic [2*ACC_BITS-1:0]        in_word;
    logic [SAMPLE_BITS-1:0]       in_re, in_im;

    function automatic logic [OUT_BITS-1:0] scale_sat(input logic [ACC_BITS-1:0] v,
                                                      input logic inv);
        logic signed [ACC_BITS-1:0] x;
        logic [OUT_BITS-1:0]        r;
        x = inv ? (signed'(v) >>> LOG2_POINTS) : signed'(v);
        if (x[ACC_BITS-1:OUT_BITS-1] == '0 || x[ACC_BITS-1:OUT_BITS-1] == '1)
        begin
            r = x[OUT_BITS-1:0];
        end
        else if (x[ACC_BITS-1])
        begin
            r = {1'b1, {(OUT_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(OUT_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    assign tw    = twiddle(cmd.tw_idx);
    assign wi    = cmd.inv ? tw.s : -tw.s;
    assign ar    = a_reg[ACC_BITS-1:0];
    assign ai    = a_reg[2*ACC_BITS-1:ACC_BITS];
    assign br    = b_reg[ACC_BITS-1:0];
    assign bi    = b_reg[2*ACC_BITS-1:ACC_BITS];
    assign dr    = DIFF_BITS'(ar) - DIFF_BITS'(br);
    assign di    = DIFF_BITS'(ai) - DIFF_BITS'(bi);
    assign sum_re = ACC_BITS'(ar + br);
    assign sum_im = ACC_BITS'(ai + bi);

    assign diff_re = (PROD_BITS+1)'(p_rc_reg) - (PROD_BITS+1)'(p_iw_reg);
    assign diff_im = (PROD_BITS+1)'(p_rw_reg) + (PROD_BITS+1)'(p_ic_reg);
    assign diff_word = {ACC_BITS'(diff_im >>> TW_FRAC), ACC_BITS'(diff_re >>> TW_FRAC)};

    assign in_re   = in_data[SAMPLE_BITS-1:0];
    assign in_im   = in_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign in_word = {{(ACC_BITS-SAMPLE_BITS){in_im[SAMPLE_BITS-1]}}, in_im,
                      {(ACC_BITS-SAMPLE_BITS){in_re[SAMPLE_BITS-1]}}, in_re};

    always_comb
    begin
        case (cmd.work_wsel)
            WSEL_SUM:  work_wdata = sum_reg;
            WSEL_DIFF: work_wdata = diff_word;
            default:   work_wdata = in_word;
        endcase
    end

    assign res_wdata = {scale_sat(work_rdata[2*ACC_BITS-1:ACC_BITS], cmd.inv),
                        scale_sat(work_rdata[ACC_BITS-1:0], cmd.inv)};

    rfft_ram #(
        .WIDTH (2 * ACC_BITS),
        .DEPTH (POINTS)
    ) u_work_ram (
        .clk   (clk),
        .we    (cmd.work_we),
        .waddr (cmd.work_waddr),
        .wdata (work_wdata),
        .raddr (cmd.work_raddr),
        .rdata (work_rdata)
    );

    rfft_ram #(
        .WIDTH (2 * OUT_BITS),
        .DEPTH (POINTS)
    ) u_result_ram (
        .clk   (clk),
        .we    (cmd.res_we),
        .waddr (cmd.res_waddr),
        .wdata (res_wdata),
        .raddr (cmd.res_raddr),
        .rdata (res_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.latch_a)
        begin
            a_reg <= work_rdata;
        end
        if (cmd.latch_b)
        begin
            b_reg <= work_rdata;
        end
        if (cmd.mul_en)
        begin
            sum_reg  <= {sum_im, sum_re};
            p_rc_reg <= dr * tw.c;
            p_iw_reg <= di * wi;
            p_rw_reg <= dr * wi;
            p_ic_reg <= di * tw.c;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res_rdata;
            out_last_reg <= cmd.out_last;
        end
    end

    assign out_data = out_data_reg;
    assign out_last = out_last_reg;

endmodule

// File: hdl/rfft_ctrl.sv
// ----------------------------------------------------------------------------
// rfft_ctrl: frame sequencer
// Stream handshakes, sample counting, butterfly and stage sequencing,
// result copy sweep, mode latching.
// ----------------------------------------------------------------------------
module rfft_ctrl
    import rfft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  logic cfg_wr_en,
    input  logic cfg_wr_data,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL_WAIT,
        ST_RD_A,
        ST_RD_B,
        ST_CAP_B,
        ST_MUL,
        ST_WR_A,
        ST_WR_B,
        ST_COPY_RD,
        ST_COPY_WR
    } state_t;

    localparam logic [LOG2_POINTS-1:0] LAST_SAMPLE = LOG2_POINTS'(POINTS - 1);
    localparam logic [LOG2_POINTS-2:0] LAST_BF     = (LOG2_POINTS-1)'(POINTS / 2 - 1);
    localparam logic [STAGE_BITS-1:0]  LAST_STAGE  = STAGE_BITS'(LOG2_POINTS - 1);
    localparam logic [LOG2_POINTS-1:0] HALF        = LOG2_POINTS'(POINTS / 2);

    state_t                 state_reg, state_next;
    logic [LOG2_POINTS-1:0] count_reg, count_next;
    logic [LOG2_POINTS-1:0] copy_reg, copy_next;
    logic [LOG2_POINTS-2:0] bf_reg, bf_next;
    logic [STAGE_BITS-1:0]  stage_reg, stage_next;
    logic                   mode_reg, mode_next;
    logic                   inv_reg, inv_next;
    logic                   ready_frame_reg, ready_frame_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   accept;
    logic [LOG2_POINTS-1:0] half_mask, bf_ext, ia, ib;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    assign half_mask = (HALF >> stage_reg) - 1'b1;
    assign bf_ext    = {1'b0, bf_reg};
    assign ia        = ((bf_ext & ~half_mask) << 1) | (bf_ext & half_mask);
    assign ib        = ia | (half_mask + 1'b1);

    always_comb
    begin
        cmd            = '0;
        cmd.work_wsel  = WSEL_INPUT;
        cmd.work_raddr = ia;
        cmd.work_waddr = count_reg;
        cmd.tw_idx     = (LOG2_POINTS-1)'((bf_ext & half_mask) << stage_reg);
        cmd.inv        = inv_reg;
        cmd.res_waddr  = copy_reg;
        cmd.res_raddr  = count_reg;
        cmd.out_last   = (count_reg == LAST_SAMPLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.work_we  = accept;
                cmd.out_load = accept && ready_frame_reg;
            end
            ST_RD_B:
            begin
                cmd.work_raddr = ib;
                cmd.latch_a    = 1'b1;
            end
            ST_CAP_B:
            begin
                cmd.latch_b = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
            end
            ST_WR_A:
            begin
                cmd.work_we    = 1'b1;
                cmd.work_wsel  = WSEL_SUM;
                cmd.work_waddr = ia;
            end
            ST_WR_B:
            begin
                cmd.work_we    = 1'b1;
                cmd.work_wsel  = WSEL_DIFF;
                cmd.work_waddr = ib;
            end
            ST_COPY_RD:
            begin
                cmd.work_raddr = copy_reg;
            end
            ST_COPY_WR:
            begin
                cmd.work_raddr = copy_reg;
                cmd.res_we     = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        copy_next        = copy_reg;
        bf_next          = bf_reg;
        stage_next       = stage_reg;
        mode_next        = cfg_wr_en ? cfg_wr_data : mode_reg;
        inv_next         = inv_reg;
        ready_frame_next = ready_frame_reg;
        out_valid_next   = out_valid_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept && ready_frame_reg)
        begin
            out_valid_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg == LAST_SAMPLE)
                    begin
                        inv_next         = mode_reg;
                        ready_frame_next = 1'b1;
                        count_next       = '0;
                        bf_next          = '0;
                        stage_next       = '0;
                        state_next       = ST_RD_A;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        state_next = ST_FILL_WAIT;
                    end
                end
            end
            ST_FILL_WAIT: state_next = ST_IDLE;
            ST_RD_A:      state_next = ST_RD_B;
            ST_RD_B:      state_next = ST_CAP_B;
            ST_CAP_B:     state_next = ST_MUL;
            ST_MUL:       state_next = ST_WR_A;
            ST_WR_A:      state_next = ST_WR_B;
            ST_WR_B:
            begin
                state_next = ST_RD_A;
                bf_next    = bf_reg + 1'b1;
                if (bf_reg == LAST_BF)
                begin
                    bf_next = '0;
                    if (stage_reg == LAST_STAGE)
                    begin
                        copy_next  = '0;
                        state_next = ST_COPY_RD;
                    end
                    else
                    begin
                        stage_next = stage_reg + 1'b1;
                    end
                end
            end
            ST_COPY_RD:   state_next = ST_COPY_WR;
            ST_COPY_WR:
            begin
                copy_next  = copy_reg + 1'b1;
                state_next = (copy_reg == LAST_SAMPLE) ? ST_FILL_WAIT : ST_COPY_RD;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            copy_reg        <= '0;
            bf_reg          <= '0;
            stage_reg       <= '0;
            mode_reg        <= 1'b0;
            inv_reg         <= 1'b0;
            ready_frame_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            copy_reg        <= copy_next;
            bf_reg          <= bf_next;
            stage_reg       <= stage_next;
            mode_reg        <= mode_next;
            inv_reg         <= inv_next;
            ready_frame_reg <= ready_frame_next;
            out_valid_reg   <= out_valid_next;
        end
    end

endmodule

// File: hdl/radix2_fixed_point_fft_core.sv
// ----------------------------------------------------------------------------
// radix2_fixed_point_fft_core: 64-point radix-2 DIF FFT / IFFT
// Bin q of a frame leaves in bit-reversed order in the cycle after sample q
// of the next frame is accepted. Filling adds a wait state after each sample.
// After the last sample the in-place transform steps each butterfly through
// read A, read B, capture B, multiply, write A and B on one work-memory port.
// Reset clears control state only; no output until one frame has completed.
// ----------------------------------------------------------------------------
module radix2_fixed_point_fft_core
    import rfft_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // in_real, in_imag
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // out_real, out_imag, zero pad
    output logic                      m_tlast,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data
);

    cmd_t                  cmd;
    logic [2*OUT_BITS-1:0] out_data;

    rfft_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd)
    );

    rfft_datapath u_datapath (
        .clk      (clk),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .out_data (out_data),
        .out_last (m_tlast)
    );

    assign m_tdata = {{(OUT_TDATA_BITS - 2*OUT_BITS){1'b0}}, out_data};

endmodule
